FILE: design/hmsl_pkg.sv
// ----------------------------------------------------------------------------
// hmsl_pkg
// Shared constants and types of the hashed mnemonic sorted lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package hmsl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned HASH_W          = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CFG_W           = 6;
  localparam int unsigned POS_W           = 5;
  localparam int unsigned IN_DATA_W       = 40;
  localparam int unsigned OUT_DATA_W      = 8;

  localparam logic [HASH_W-1:0] HASH_SEED       = 32'd5381;
  localparam logic [CFG_W-1:0]  ENTRY_COUNT_RST = 6'd29;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

endpackage

`default_nettype wire

FILE: design/hmsl_hash.sv
// ----------------------------------------------------------------------------
// hmsl_hash
// Running djb2 hash: hash * 33 + sign-extended byte, restart at seed on last.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsl_hash
  import hmsl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              last_i,
  output logic      [HASH_W-1:0] hash_next_o
);

  logic [HASH_W-1:0] hash_q, hash_d;
  logic [HASH_W-1:0] byte_ext;

  assign byte_ext    = {{(HASH_W-BYTE_W){byte_i[BYTE_W-1]}}, byte_i};
  assign hash_next_o = (hash_q << 5) + hash_q + byte_ext;

  always_comb begin
    hash_d = hash_q;
    if (step_i) begin
      hash_d = last_i ? HASH_SEED : hash_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_SEED;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/hmsl_table.sv
// ----------------------------------------------------------------------------
// hmsl_table
// Hash table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsl_table
  import hmsl_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [HASH_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [HASH_W-1:0] rdata_o
);

  logic [HASH_W-1:0] mem_q [DEPTH];
  logic [HASH_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/hmsl_cmp.sv
// ----------------------------------------------------------------------------
// hmsl_cmp
// Shared 32-bit magnitude comparator for insertion and search.
// ----------------------------------------------------------------------------
`default_nettype none

module hmsl_cmp
  import hmsl_pkg::*;
(
  input  wire logic [HASH_W-1:0] a_i,
  input  wire logic [HASH_W-1:0] b_i,
  output cmp_t                   res_o
);

  always_comb begin
    res_o.lt = a_i < b_i;
    res_o.eq = a_i == b_i;
    res_o.gt = a_i > b_i;
  end

endmodule

`default_nettype wire

FILE: design/hashed_mnemonic_sorted_lookup.sv
// Load: a non-final load beat only steps the hash; a final load beat inserts the hash,
//   reading, comparing and shifting up each stored entry that it moves past.
// Search: binary search of the n stored entries through a read/compare loop on the one
//   table read port; a search before ready goes straight to the output; output stalls hold it.
// Throughput: one beat at a time; input ready only while the sequencer idles.
// Reset: table empty and not ready, hash at seed, entry_count 29; memory not cleared.
// ----------------------------------------------------------------------------
// hashed_mnemonic_sorted_lookup
// Builds a sorted table of djb2 name hashes and binary-searches it for keys.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_mnemonic_sorted_lookup
  import hmsl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // name_byte[7:0], key_hash[39:8]
  input  wire logic                  s_axis_tuser_i,   // opcode
  input  wire logic                  s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata_o,   // position[4:0], zero pad
  output logic                       m_axis_tuser_o,   // found
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS_RD   = 7'b0000010,
    ST_INS_CMP  = 7'b0000100,
    ST_SRCH_RD  = 7'b0001000,
    ST_SRCH_CMP = 7'b0010000,
    ST_FIN_CMP  = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  count_q, count_d;
  logic [CW-1:0]     loaded_q, loaded_d;
  logic              ready_q, ready_d;
  logic [HASH_W-1:0] val_q, val_d;
  logic [AW-1:0]     j_q, j_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;
  logic [CW-1:0]     mid_q, mid_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              m_valid_q, m_valid_d;
  logic              m_found_q, m_found_d;
  logic [POS_W-1:0]  m_pos_q, m_pos_d;

  logic              in_beat;
  opcode_e           in_op;
  logic [BYTE_W-1:0] in_byte;
  logic [HASH_W-1:0] in_key;
  logic              hash_step;
  logic [HASH_W-1:0] hash_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [HASH_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [HASH_W-1:0] rdata;
  logic [HASH_W-1:0] cmp_b;
  cmp_t              cmp;

  logic [CW-1:0]     loaded_inc;
  logic              done_fill;
  logic [CW-1:0]     mid_calc;
  logic [CW+POS_W-1:0] lo_ext;
  logic              out_free;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op     = opcode_e'(s_axis_tuser_i);
  assign in_byte   = s_axis_tdata_i[BYTE_W-1:0];
  assign in_key    = s_axis_tdata_i[BYTE_W +: HASH_W];
  assign hash_step = in_beat && (in_op == OP_LOAD) && !ready_q;

  hmsl_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (hash_step),
    .byte_i      (in_byte),
    .last_i      (s_axis_tlast_i),
    .hash_next_o (hash_next)
  );

  hmsl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cmp_b = val_q;

  hmsl_cmp u_cmp (
    .a_i   (rdata),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  assign loaded_inc  = loaded_q + CW'(1);
  assign done_fill   = (CMPW'(loaded_inc) >= CMPW'(count_q)) ||
                       (loaded_inc == CW'(TABLE_DEPTH));
  assign mid_calc    = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_ext      = {{POS_W{1'b0}}, lo_q};
  assign out_free    = !m_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_found_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-POS_W){1'b0}}, m_pos_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    loaded_d  = loaded_q;
    ready_d   = ready_q;
    val_d     = val_q;
    j_d       = j_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    found_d   = found_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q;
    m_found_d = m_found_q;
    m_pos_d   = m_pos_q;
    we        = 1'b0;
    waddr     = j_q;
    wdata     = val_q;
    raddr     = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      count_d = cfg_data_i;
    end
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_op == OP_LOAD) begin
            if (!ready_q && s_axis_tlast_i) begin
              val_d = hash_next;
              if (loaded_q == CW'(TABLE_DEPTH)) begin
                ready_d = 1'b1;
              end else begin
                j_d     = loaded_q[AW-1:0];
                state_d = ST_INS_RD;
              end
            end
          end else begin
            val_d   = in_key;
            found_d = 1'b0;
            pos_d   = '0;
            lo_d    = '0;
            hi_d    = loaded_q;
            state_d = ready_q ? ST_SRCH_RD : ST_OUT;
          end
        end
      end
      ST_INS_RD: begin
        if (j_q == '0) begin
          we       = 1'b1;
          loaded_d = loaded_inc;
          ready_d  = done_fill;
          state_d  = ST_IDLE;
        end else begin
          raddr   = j_q - AW'(1);
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (cmp.gt) begin
          wdata   = rdata;
          j_d     = j_q - AW'(1);
          state_d = ST_INS_RD;
        end else begin
          loaded_d = loaded_inc;
          ready_d  = done_fill;
          state_d  = ST_IDLE;
        end
      end
      ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          raddr   = mid_calc[AW-1:0];
          mid_d   = mid_calc;
          state_d = ST_SRCH_CMP;
        end else if (lo_q < loaded_q) begin
          raddr   = lo_q[AW-1:0];
          state_d = ST_FIN_CMP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SRCH_CMP: begin
        if (cmp.lt) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SRCH_RD;
      end
      ST_FIN_CMP: begin
        if (cmp.eq) begin
          found_d = 1'b1;
          pos_d   = lo_ext[POS_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_found_d = found_q;
          m_pos_d   = pos_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= ENTRY_COUNT_RST;
      loaded_q  <= '0;
      ready_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      loaded_q  <= loaded_d;
      ready_q   <= ready_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    j_q       <= j_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    m_found_q <= m_found_d;
    m_pos_q   <= m_pos_d;
  end

endmodule

`default_nettype wire

FILE: tb/hashed_mnemonic_sorted_lookup_test.sv
// ----------------------------------------------------------------------------
// hashed_mnemonic_sorted_lookup_test
// Streams name bytes into the lookup block until its hash table completes,
// and checks lookups against a local hash, sort and binary-search predictor.
// Entry count is rewritten at idle points. It goes to its extremes, is
// clamped above the depth and is lowered during the load. Both stream sides
// stall at random, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_mnemonic_sorted_lookup_test;
  import hmsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH              = TABLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES      = 80;
  localparam int SEARCHES_PER_PHASE = 320;
  localparam int HOLD_OFF_CYCLES    = 300;
  localparam int DRAIN_LIMIT        = 20000;

  typedef struct packed {
    logic            is_cfg;
    opcode_e         op;
    logic [7:0]      name_byte;
    logic            last_byte;
    logic [31:0]     key;        // entry count in the low bits on config rows
    logic            typed;
    logic            found;
    logic [POS_W-1:0] position;
  } stim_row_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;   // name_byte[7:0], key_hash[39:8]
  logic                  s_axis_tuser_i = 1'b0; // opcode
  logic                  s_axis_tlast_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;        // position[4:0], zero pad
  logic                  m_axis_tuser_o;        // found
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  hashed_mnemonic_sorted_lookup u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Predictor state
  logic [31:0]      hash_entries [DEPTH];
  logic [31:0]      name_hash;
  int               entries_stored;
  bit               table_sorted;
  logic [CFG_W-1:0] entry_count_reg;

  lookup_result_t   lookup_results_due [$];
  logic [7:0]       last_name [$];
  stim_row_t        directed_rows [12];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int hold_left;

  int fail_count;
  int beats_sent;
  int lookups_sent;
  int results_seen;
  int hits_seen;
  int cfg_writes;

  always #6 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("hashed_mnemonic_sorted_lookup_test NOT OK");
    $finish;
  end

  task automatic note_failure(input string msg);
    if (fail_count < 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Hash fold, table insert with stable sort, and lower-bound search
  task automatic predict_beat(input opcode_e op, input logic [7:0] nb, input logic lst,
                              input logic [31:0] key, output bit has_result,
                              output lookup_result_t res);
    int          limit;
    int          lo;
    int          hi;
    int          mid;
    int          j;
    logic [31:0] v;
    has_result = 1'b0;
    res        = '0;
    if (op == OP_LOAD) begin
      if (!table_sorted) begin
        name_hash = name_hash * 32'd33 + {{24{nb[7]}}, nb};
        if (lst) begin
          if (entries_stored < DEPTH) begin
            hash_entries[entries_stored] = name_hash;
            entries_stored++;
          end
          name_hash = HASH_SEED;
          limit = (entry_count_reg == 0) ? 1 :
                  (int'(entry_count_reg) > DEPTH) ? DEPTH : int'(entry_count_reg);
          if (entries_stored >= limit) begin
            for (int i = 1; i < entries_stored; i++) begin
              v = hash_entries[i];
              j = i;
              while (j > 0 && hash_entries[j-1] > v) begin
                hash_entries[j] = hash_entries[j-1];
                j--;
              end
              hash_entries[j] = v;
            end
            table_sorted = 1'b1;
          end
        end
      end
    end else begin
      has_result = 1'b1;
      if (table_sorted) begin
        lo = 0;
        hi = entries_stored;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (hash_entries[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        if (lo < entries_stored && hash_entries[lo] == key) begin
          res.found    = 1'b1;
          res.position = lo[POS_W-1:0];
        end
      end
    end
  endtask

  task automatic push_item(input opcode_e op, input logic [7:0] nb, input logic lst,
                           input logic [31:0] key, input bit typed,
                           input lookup_result_t typed_res);
    bit             has_result;
    lookup_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {key, nb};
    s_axis_tuser_i  <= op;
    s_axis_tlast_i  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    beats_sent++;
    predict_beat(op, nb, lst, key, has_result, res);
    if (has_result) begin
      lookups_sent++;
      lookup_results_due.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic write_entry_count(input logic [CFG_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i     <= 1'b0;
    entry_count_reg = value;
    cfg_writes++;
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    int i;
    r = $urandom_range(0, 99);
    i = $urandom_range(0, entries_stored - 1);
    if (r < 60) return hash_entries[i];
    if (r < 70) return hash_entries[i] + 32'd1;
    if (r < 80) return hash_entries[i] - 32'd1;
    if (r < 85) return 32'h0000_0000;
    if (r < 90) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic push_search();
    push_item(OP_SEARCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              pick_key(), 1'b0, '0);
  endtask

  // Repeat the previous name now and then so equal hashes land in the table
  task automatic send_name();
    int len;
    if (last_name.size() == 0 || $urandom_range(0, 4) != 0) begin
      last_name.delete();
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) last_name.push_back(8'($urandom_range(0, 255)));
    end
    len = last_name.size();
    for (int i = 0; i < len; i++) begin
      push_item(OP_LOAD, last_name[i], i == len - 1, $urandom(), 1'b0, '0);
      if (i < len - 1 && $urandom_range(0, 9) == 0) push_search();
    end
    if ($urandom_range(0, 4) == 0) push_search();
  endtask

  task automatic load_until(input int goal);
    while (entries_stored < goal) send_name();
  endtask

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (m_axis_tuser_o === 1'b1) hits_seen++;
      if (lookup_results_due.size() == 0) begin
        note_failure($sformatf("result with nothing due: found=%b position=%0d",
                               m_axis_tuser_o, m_axis_tdata_o[POS_W-1:0]));
      end else begin
        want = lookup_results_due.pop_front();
        if (m_axis_tuser_o !== want.found ||
            m_axis_tdata_o[POS_W-1:0] !== want.position) begin
          note_failure($sformatf({"lookup %0d: expected found=%b position=%0d,",
                                  " got found=%b position=%0d"},
                                 results_seen, want.found, want.position,
                                 m_axis_tuser_o, m_axis_tdata_o[POS_W-1:0]));
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    name_hash       = HASH_SEED;
    entries_stored  = 0;
    table_sorted    = 1'b0;
    entry_count_reg = ENTRY_COUNT_RST;
    hold_request    = 1'b0;
    hold_left       = 0;
    fail_count      = 0;
    beats_sent      = 0;
    lookups_sent    = 0;
    results_seen    = 0;
    hits_seen       = 0;
    cfg_writes      = 0;
    send_idle_pct   = 25;
    recv_idle_pct   = 57;

    directed_rows = '{
      '{1'b0, OP_SEARCH, 8'h00, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 5'd0},
      '{1'b0, OP_SEARCH, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0},
      '{1'b1, OP_LOAD,   8'h00, 1'b0, 32'd63,        1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'h00, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'hFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'h80, 1'b0, 32'h5555_AAAA, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'h7F, 1'b1, 32'hAAAA_5555, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'h01, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'h01, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_LOAD,   8'hFE, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 5'd0},
      '{1'b0, OP_SEARCH, 8'h5A, 1'b0, 32'h0002_B5A6, 1'b1, 1'b0, 5'd0},
      '{1'b0, OP_SEARCH, 8'hA5, 1'b1, 32'hAAAA_5555, 1'b0, 1'b0, 5'd0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        write_entry_count(row.key[CFG_W-1:0]);
      end else begin
        push_item(row.op, row.name_byte, row.last_byte, row.key, row.typed,
                  lookup_result_t'{row.found, row.position});
      end
    end

    // Load with the count above depth, then lower it to zero at the end
    load_until(12);
    write_entry_count(CFG_W'($urandom_range(33, 63)));
    load_until(22);
    write_entry_count(CFG_W'(DEPTH));
    load_until(DEPTH - 1);
    write_entry_count('0);
    send_name();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        write_entry_count(CFG_W'(1));
        send_idle_pct = 57;
        recv_idle_pct = 25;
      end else if (ph == 2) begin
        write_entry_count(CFG_W'($urandom_range(0, 63)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
      end
      for (int k = 0; k < SEARCHES_PER_PHASE; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          push_item(OP_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    $urandom(), 1'b0, '0);
        end
        push_search();
      end
    end

    s_axis_tvalid_i <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && lookup_results_due.size() != 0; w++) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (lookup_results_due.size() != 0) begin
      note_failure($sformatf("%0d lookups never answered", lookup_results_due.size()));
    end

    $display("sent %0d beats, %0d lookups, %0d answered (%0d hits)",
             beats_sent, lookups_sent, results_seen, hits_seen);
    $display("table held %0d entries, entry count written %0d times, %0d failures",
             entries_stored, cfg_writes, fail_count);
    if (fail_count == 0) begin
      $display("hashed_mnemonic_sorted_lookup_test OK");
    end else begin
      $display("hashed_mnemonic_sorted_lookup_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
